/* src/wlg8_pkg.sv */
`default_nettype none

package wlg8_pkg;

    localparam int WIDTH_BITS = 16;
    localparam int LEVEL_BITS = 16;
    localparam int GRAY_BITS  = 8;
    localparam int NUM_BITS   = WIDTH_BITS + GRAY_BITS;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [GRAY_BITS-1:0]  GRAY_MIN      = '0;
    localparam logic [GRAY_BITS-1:0]  GRAY_MAX      = 8'd255;
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET   = 16'd256;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MIN     = 16'd1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET   = 16'sd128;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WINDOW_WIDTH = 1'b0,
        REG_WINDOW_LEVEL = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SAT_NONE,
        SAT_LOW,
        SAT_HIGH
    } t_sat;

    typedef struct packed {
        t_sat                 sat;
        logic [NUM_BITS-1:0]  rem;
        logic [GRAY_BITS-1:0] quo;
    } t_div_word;

endpackage

`default_nettype wire

/* src/window_level_to_gray8.sv */
`default_nettype none

// Window/level mapping of a signed raw sample to an 8-bit gray word. Samples below
// level - floor(width/2) give 0, samples above level + floor(width/2) give 255, and
// the rest give floor(255 * (sample - level + floor(width/2)) / width). A new word is
// taken every clock while the output is not held; each word passes through the input
// register, the offset and range stage, the times-255 stage, the eight-stage restoring
// divider (one quotient bit per stage) and the output register. Any stage with a free
// slot keeps taking words while the output waits. Width and level are to be written by
// the user through the register port only while no word is in flight; the block itself
// does not enforce this. A width of zero is stored as one.

module window_level_to_gray8 #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_cfg_we,
    input  wire  [wlg8_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  wire  [wlg8_pkg::WIDTH_BITS-1:0]         i_cfg_wdata,
    input  wire                                     i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // sample
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]        i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire                                     i_m_axis_tready,
    // gray
    output logic [wlg8_pkg::GRAY_BITS-1:0]          o_m_axis_tdata
);
    import wlg8_pkg::*;

    localparam int DW = ((SAMPLE_BITS > WIDTH_BITS) ? SAMPLE_BITS : WIDTH_BITS + 1) + 2;

    logic [WIDTH_BITS-1:0]        r_width;
    logic signed [LEVEL_BITS-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
            r_level <= LEVEL_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_WINDOW_WIDTH: r_width <= (i_cfg_wdata == '0) ? WIDTH_MIN : i_cfg_wdata;
                REG_WINDOW_LEVEL: r_level <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage a: input register
    logic                   r_a_v;
    logic [SAMPLE_BITS-1:0] r_a_sample;
    // stage b: offset and range
    logic                   r_b_v;
    t_sat                   r_b_sat;
    logic [WIDTH_BITS-1:0]  r_b_off;
    // stage c: numerator
    logic                   r_c_v;
    t_div_word              r_c_word;
    // output register
    logic                   r_o_v;
    logic [GRAY_BITS-1:0]   r_o_gray;

    logic      rdy_a, rdy_b, rdy_c, rdy_o;
    logic      div_ready, div_valid;
    t_div_word div_word;

    assign rdy_o = !r_o_v || i_m_axis_tready;
    assign rdy_c = !r_c_v || div_ready;
    assign rdy_b = !r_b_v || rdy_c;
    assign rdy_a = !r_a_v || rdy_b;
    assign o_s_axis_tready = rdy_a;

    logic signed [DW-1:0] s_ext, l_ext, h_ext, span, n_off;
    t_sat                 n_sat;

    always_comb begin
        s_ext = {{(DW-SAMPLE_BITS){r_a_sample[SAMPLE_BITS-1]}}, r_a_sample};
        l_ext = {{(DW-LEVEL_BITS){r_level[LEVEL_BITS-1]}}, r_level};
        h_ext = {{(DW-WIDTH_BITS+1){1'b0}}, r_width[WIDTH_BITS-1:1]};
        span  = {{(DW-WIDTH_BITS){1'b0}}, r_width[WIDTH_BITS-1:1], 1'b0};
        n_off = s_ext - l_ext + h_ext;
        if (n_off < 0) begin
            n_sat = SAT_LOW;
        end else if (n_off > span) begin
            n_sat = SAT_HIGH;
        end else begin
            n_sat = SAT_NONE;
        end
    end

    t_div_word n_c_word;

    always_comb begin
        n_c_word.sat = r_b_sat;
        n_c_word.rem = {r_b_off, {GRAY_BITS{1'b0}}} - {{GRAY_BITS{1'b0}}, r_b_off};
        n_c_word.quo = '0;
    end

    logic [GRAY_BITS-1:0] n_o_gray;

    always_comb begin
        case (div_word.sat)
            SAT_LOW:  n_o_gray = GRAY_MIN;
            SAT_HIGH: n_o_gray = GRAY_MAX;
            default:  n_o_gray = div_word.quo;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (rdy_a) r_a_v <= i_s_axis_tvalid;
            if (rdy_b) r_b_v <= r_a_v;
            if (rdy_c) r_c_v <= r_b_v;
            if (rdy_o) r_o_v <= div_valid;
        end
        if (rdy_a && i_s_axis_tvalid) begin
            r_a_sample <= i_s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (rdy_b && r_a_v) begin
            r_b_sat <= n_sat;
            r_b_off <= n_off[WIDTH_BITS-1:0];
        end
        if (rdy_c && r_b_v) begin
            r_c_word <= n_c_word;
        end
        if (rdy_o && div_valid) begin
            r_o_gray <= n_o_gray;
        end
    end

    wlg8_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_width (r_width),
        .i_valid (r_c_v),
        .o_ready (div_ready),
        .i_word  (r_c_word),
        .o_valid (div_valid),
        .i_ready (rdy_o),
        .o_word  (div_word)
    );

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = r_o_gray;

endmodule

`default_nettype wire

/* src/wlg8_div.sv */
`default_nettype none

module wlg8_div (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  [wlg8_pkg::WIDTH_BITS-1:0]     i_width,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wlg8_pkg::t_div_word                 i_word,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output wlg8_pkg::t_div_word                 o_word
);
    import wlg8_pkg::*;

    localparam int STAGES = GRAY_BITS;

    logic      r_v [STAGES];
    t_div_word r_w [STAGES];
    t_div_word n_w [STAGES];
    logic      rdy [STAGES+1];

    assign rdy[STAGES] = i_ready;

    // restoring division, one quotient bit per stage, msb first
    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        localparam int SH = STAGES - 1 - j;
        logic                in_v;
        t_div_word           in_w;
        logic [NUM_BITS-1:0] div_sh;

        if (j == 0) begin : g_first
            assign in_v = i_valid;
            assign in_w = i_word;
        end else begin : g_next
            assign in_v = r_v[j-1];
            assign in_w = r_w[j-1];
        end

        assign rdy[j]  = !r_v[j] || rdy[j+1];
        assign div_sh  = {{GRAY_BITS{1'b0}}, i_width} << SH;

        always_comb begin
            n_w[j] = in_w;
            if (in_w.rem >= div_sh) begin
                n_w[j].rem     = in_w.rem - div_sh;
                n_w[j].quo[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (rdy[j]) begin
                r_v[j] <= in_v;
            end
            if (rdy[j] && in_v) begin
                r_w[j] <= n_w[j];
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[STAGES-1];
    assign o_word  = r_w[STAGES-1];

endmodule

`default_nettype wire
